@@ design/pair_union_find_with_conflict_check_unit_assert.svh @@
`ifndef PAIR_UNION_FIND_WITH_CONFLICT_CHECK_UNIT_ASSERT_SVH
`define PAIR_UNION_FIND_WITH_CONFLICT_CHECK_UNIT_ASSERT_SVH

// same-cycle implication
`define PUF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PUF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/puf_pkg.sv @@
package puf_pkg;

  localparam int MAX_PAIRS = 64;
  localparam int IDX_W     = 6;
  localparam int SIZE_W    = 7;
  localparam int LET_W     = 5;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_UNITE  = 3'd1;
  localparam logic [2:0] CMD_SIZE   = 3'd2;
  localparam logic [2:0] CMD_LOOKUP = 3'd3;
  localparam logic [2:0] CMD_SAME   = 3'd4;
  localparam logic [2:0] CMD_MARK   = 3'd5;
  localparam logic [2:0] CMD_TRUTH  = 3'd6;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_BAD_MARK  = 2'd2;
  localparam logic [1:0] STAT_NOT_ADDED = 2'd3;

  typedef struct packed {
    logic [LET_W-1:0]  letter_first;
    logic [LET_W-1:0]  letter_second;
    logic              truth;
    logic [IDX_W-1:0]  parent;
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  ring;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_FIND_RD,
    ST_FIND_CHK,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_WR_A,
    ST_WR_B,
    ST_LOOK_RD,
    ST_LOOK_CMP,
    ST_DONE
  } state_t;

  function automatic logic pairs_conflict(input entry_t x, input entry_t y);
    logic [LET_W-1:0] a1, a2, b1, b2;
    a1 = x.letter_first;
    a2 = x.letter_second;
    b1 = y.letter_first;
    b2 = y.letter_second;
    return (a1 == b1 && a2 != b2) || (a1 == b2 && a2 != b1) ||
           (b1 == a2 && b2 != a1) || (a2 == b2 && a1 != b1);
  endfunction

endpackage

@@ design/puf_mem.sv @@
module puf_mem (
  input  logic                        clk,
  input  logic                        we,
  input  logic [puf_pkg::IDX_W-1:0]   waddr,
  input  puf_pkg::entry_t             wdata,
  input  logic [puf_pkg::IDX_W-1:0]   raddr_a,
  input  logic [puf_pkg::IDX_W-1:0]   raddr_b,
  output puf_pkg::entry_t             rdata_a,
  output puf_pkg::entry_t             rdata_b
);

  puf_pkg::entry_t mem [puf_pkg::MAX_PAIRS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ design/pair_union_find_with_conflict_check_unit.sv @@
// Command flow up to m_tvalid: add finishes in the start state; size, truth, same set,
// mark walk the parent chain entry by entry (at most seven); lookup reads entries one by one.
// Unite walks both chains, compares member pairs while both sets are true, then writes back.
// One command in flight at a time; the next is taken while a result waits in m_tdata,
// and a full output register holds the block in its last state.
// Reset clears pair count, control and output valid; table entries stay undefined.
`include "pair_union_find_with_conflict_check_unit_assert.svh"

module pair_union_find_with_conflict_check_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[2:0], index_a[8:3], index_b[14:9], letter_a[19:15], letter_b[24:20],
  // mark_value[26:25], zero fill above
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], result_value[8:2], result_flag[9], contradiction[10], zero fill
  output logic [15:0] m_tdata
);

  localparam int IW = puf_pkg::IDX_W;
  localparam int SW = puf_pkg::SIZE_W;
  localparam int LW = puf_pkg::LET_W;

  puf_pkg::state_t state, state_next;

  logic [2:0]    cmd;
  logic [IW-1:0] ia, ib;
  logic [LW-1:0] la, lb;
  logic [1:0]    mv;
  logic [SW-1:0] count, count_next;
  logic [IW-1:0] ca, ca_next, cb, cb_next, x, x_next, y, y_next, k, k_next;
  logic          done_a, done_a_next, done_b, done_b_next;
  logic          keep_b, keep_b_next, new_truth, new_truth_next;
  puf_pkg::entry_t ea, ea_next, eb, eb_next;
  logic [1:0]    rstat, rstat_next;
  logic [SW-1:0] rval, rval_next;
  logic          rflag, rflag_next, rcontra, rcontra_next;
  logic          out_load;

  logic            we;
  logic [IW-1:0]   waddr, raddr_a, raddr_b;
  puf_pkg::entry_t wdata, rdata_a, rdata_b;
  logic [SW-1:0]   size_sum;
  logic            da, db;

  puf_mem u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign s_tready = (state == puf_pkg::ST_IDLE);
  assign size_sum = ea.size + eb.size;
  assign da       = done_a || (rdata_a.parent == ca);
  assign db       = done_b || (rdata_b.parent == cb);

  always_comb begin
    state_next     = state;
    count_next     = count;
    ca_next        = ca;
    cb_next        = cb;
    x_next         = x;
    y_next         = y;
    k_next         = k;
    done_a_next    = done_a;
    done_b_next    = done_b;
    keep_b_next    = keep_b;
    new_truth_next = new_truth;
    ea_next        = ea;
    eb_next        = eb;
    rstat_next     = rstat;
    rval_next      = rval;
    rflag_next     = rflag;
    rcontra_next   = rcontra;
    out_load       = 1'b0;
    we             = 1'b0;
    waddr          = ca;
    wdata          = ea;
    raddr_a        = ca;
    raddr_b        = cb;
    unique case (state)
      puf_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          rstat_next   = puf_pkg::STAT_OK;
          rval_next    = '0;
          rflag_next   = 1'b0;
          rcontra_next = 1'b0;
          state_next   = puf_pkg::ST_START;
        end
      end
      puf_pkg::ST_START: begin
        ca_next     = ia;
        cb_next     = ib;
        done_a_next = 1'b0;
        done_b_next = !(cmd == puf_pkg::CMD_UNITE || cmd == puf_pkg::CMD_SAME);
        k_next      = '0;
        state_next  = puf_pkg::ST_DONE;
        unique case (cmd)
          puf_pkg::CMD_ADD: begin
            if (count == SW'(puf_pkg::MAX_PAIRS)) begin
              rstat_next = puf_pkg::STAT_FULL;
            end else begin
              we          = 1'b1;
              waddr       = count[IW-1:0];
              wdata       = '{letter_first: la, letter_second: lb, truth: 1'b1,
                              parent: count[IW-1:0], size: SW'(1),
                              ring: count[IW-1:0]};
              count_next  = count + SW'(1);
              rval_next   = count;
            end
          end
          puf_pkg::CMD_UNITE, puf_pkg::CMD_SAME: begin
            if ({1'b0, ia} >= count || {1'b0, ib} >= count) begin
              rstat_next = puf_pkg::STAT_NOT_ADDED;
            end else begin
              state_next = puf_pkg::ST_FIND_RD;
            end
          end
          puf_pkg::CMD_SIZE, puf_pkg::CMD_TRUTH, puf_pkg::CMD_MARK: begin
            if (cmd == puf_pkg::CMD_MARK && mv[1]) begin
              rstat_next = puf_pkg::STAT_BAD_MARK;
            end else if ({1'b0, ia} >= count) begin
              rstat_next = puf_pkg::STAT_NOT_ADDED;
            end else begin
              state_next = puf_pkg::ST_FIND_RD;
            end
          end
          puf_pkg::CMD_LOOKUP: begin
            if (count != '0) begin
              state_next = puf_pkg::ST_LOOK_RD;
            end
          end
          default: begin
          end
        endcase
      end
      puf_pkg::ST_FIND_RD: begin
        state_next = puf_pkg::ST_FIND_CHK;
      end
      puf_pkg::ST_FIND_CHK: begin
        if (!done_a) begin
          if (rdata_a.parent == ca) ea_next = rdata_a;
          else ca_next = rdata_a.parent;
        end
        if (!done_b) begin
          if (rdata_b.parent == cb) eb_next = rdata_b;
          else cb_next = rdata_b.parent;
        end
        done_a_next = da;
        done_b_next = db;
        state_next  = (da && db) ? puf_pkg::ST_EXEC : puf_pkg::ST_FIND_RD;
      end
      puf_pkg::ST_EXEC: begin
        state_next = puf_pkg::ST_DONE;
        unique case (cmd)
          puf_pkg::CMD_SIZE:  rval_next  = ea.size;
          puf_pkg::CMD_TRUTH: rflag_next = ea.truth;
          puf_pkg::CMD_SAME:  rflag_next = (ca == cb);
          puf_pkg::CMD_MARK: begin
            we          = 1'b1;
            waddr       = ca;
            wdata       = ea;
            wdata.truth = mv[0];
          end
          puf_pkg::CMD_UNITE: begin
            if (ca == cb) begin
              rval_next  = ea.size;
              rflag_next = ea.truth;
            end else begin
              keep_b_next    = (ea.size < eb.size);
              new_truth_next = ea.truth & eb.truth;
              x_next         = cb;
              y_next         = ca;
              state_next     = (ea.truth & eb.truth) ? puf_pkg::ST_SCAN_RD
                                                     : puf_pkg::ST_WR_A;
            end
          end
          default: begin
          end
        endcase
      end
      puf_pkg::ST_SCAN_RD: begin
        raddr_a    = x;
        raddr_b    = y;
        state_next = puf_pkg::ST_SCAN_CMP;
      end
      puf_pkg::ST_SCAN_CMP: begin
        if (puf_pkg::pairs_conflict(rdata_a, rdata_b)) begin
          new_truth_next = 1'b0;
          rcontra_next   = 1'b1;
          state_next     = puf_pkg::ST_WR_A;
        end else if (rdata_b.ring != ca) begin
          y_next     = rdata_b.ring;
          state_next = puf_pkg::ST_SCAN_RD;
        end else if (rdata_a.ring != cb) begin
          x_next     = rdata_a.ring;
          y_next     = ca;
          state_next = puf_pkg::ST_SCAN_RD;
        end else begin
          state_next = puf_pkg::ST_WR_A;
        end
      end
      puf_pkg::ST_WR_A: begin
        we         = 1'b1;
        waddr      = ca;
        wdata      = ea;
        wdata.ring = eb.ring;
        if (keep_b) begin
          wdata.parent = cb;
        end else begin
          wdata.size  = size_sum;
          wdata.truth = new_truth;
        end
        state_next = puf_pkg::ST_WR_B;
      end
      puf_pkg::ST_WR_B: begin
        we         = 1'b1;
        waddr      = cb;
        wdata      = eb;
        wdata.ring = ea.ring;
        if (keep_b) begin
          wdata.size  = size_sum;
          wdata.truth = new_truth;
        end else begin
          wdata.parent = ca;
        end
        rval_next  = size_sum;
        rflag_next = new_truth;
        state_next = puf_pkg::ST_DONE;
      end
      puf_pkg::ST_LOOK_RD: begin
        raddr_a    = k;
        state_next = puf_pkg::ST_LOOK_CMP;
      end
      puf_pkg::ST_LOOK_CMP: begin
        if ((rdata_a.letter_first == la && rdata_a.letter_second == lb) ||
            (rdata_a.letter_second == la && rdata_a.letter_first == lb)) begin
          rval_next  = SW'(k);
          rflag_next = 1'b1;
          state_next = puf_pkg::ST_DONE;
        end else if ({1'b0, k} == count - SW'(1)) begin
          state_next = puf_pkg::ST_DONE;
        end else begin
          k_next     = k + IW'(1);
          state_next = puf_pkg::ST_LOOK_RD;
        end
      end
      puf_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = puf_pkg::ST_IDLE;
        end
      end
      default: state_next = puf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= puf_pkg::ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= s_tdata[2:0];
      ia  <= s_tdata[8:3];
      ib  <= s_tdata[14:9];
      la  <= s_tdata[19:15];
      lb  <= s_tdata[24:20];
      mv  <= s_tdata[26:25];
    end
    ca        <= ca_next;
    cb        <= cb_next;
    x         <= x_next;
    y         <= y_next;
    k         <= k_next;
    done_a    <= done_a_next;
    done_b    <= done_b_next;
    keep_b    <= keep_b_next;
    new_truth <= new_truth_next;
    ea        <= ea_next;
    eb        <= eb_next;
    rstat     <= rstat_next;
    rval      <= rval_next;
    rflag     <= rflag_next;
    rcontra   <= rcontra_next;
    if (out_load) begin
      m_tdata <= {5'd0, rcontra, rflag, rval, rstat};
    end
  end

  `PUF_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count <= SW'(puf_pkg::MAX_PAIRS), "count overflow")
  `PUF_ASSERT_NEXT(a_accept_start, clk, rst, s_tvalid && s_tready, state == puf_pkg::ST_START, "accept lost")
  `PUF_ASSERT_NOW(a_write_state, clk, rst, we, state == puf_pkg::ST_START || state == puf_pkg::ST_EXEC || state == puf_pkg::ST_WR_A || state == puf_pkg::ST_WR_B, "stray write")
  `PUF_ASSERT_NEXT(a_count_add, clk, rst, state != puf_pkg::ST_START || cmd != puf_pkg::CMD_ADD, $stable(count), "count moved")
  `PUF_ASSERT_NOW(a_load_free, clk, rst, out_load, !m_tvalid || m_tready, "result overwritten")

endmodule

@@ tb/tb.sv @@
module tb;

  localparam int WAIT_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  typedef struct packed {
    logic       contra;
    logic       flag;
    logic [6:0] value;
    logic [1:0] status;
  } answer_t;

  logic [puf_pkg::LET_W-1:0] tab_first [puf_pkg::MAX_PAIRS];
  logic [puf_pkg::LET_W-1:0] tab_second[puf_pkg::MAX_PAIRS];
  logic                      tab_truth [puf_pkg::MAX_PAIRS];
  int                        tab_parent[puf_pkg::MAX_PAIRS];
  int                        tab_size  [puf_pkg::MAX_PAIRS];
  int                        tab_ring  [puf_pkg::MAX_PAIRS];
  int                        pairs_added;

  answer_t answers_due[$];
  int      errors;
  int      sent_cnt;
  int      got_cnt;
  int      contra_cnt;
  int      idle_cycles;
  int      rx_wait;
  int      rx_draw;
  bit      hold_off;
  bit      rx_stall_on;

  pair_union_find_with_conflict_check_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  function automatic int find_root(int i);
    int r;
    int p;
    int up;
    r = i;
    while (tab_parent[r] != r) r = tab_parent[r];
    p = i;
    while (p != r) begin
      up = tab_parent[p];
      tab_parent[p] = r;
      p = up;
    end
    return r;
  endfunction

  function automatic bit letters_clash(int x, int y);
    logic [puf_pkg::LET_W-1:0] a1, a2, b1, b2;
    a1 = tab_first[x];
    a2 = tab_second[x];
    b1 = tab_first[y];
    b2 = tab_second[y];
    return (a1 == b1 && a2 != b2) || (a1 == b2 && a2 != b1) ||
           (b1 == a2 && b2 != a1) || (a2 == b2 && a1 != b1);
  endfunction

  function automatic bit groups_clash(int ra, int rb);
    int x;
    int y;
    x = rb;
    do begin
      y = ra;
      do begin
        if (letters_clash(x, y)) return 1'b1;
        y = tab_ring[y];
      end while (y != ra);
      x = tab_ring[x];
    end while (x != rb);
    return 1'b0;
  endfunction

  function automatic answer_t run_command(logic [2:0] cmd, int ia, int ib,
                                          logic [4:0] la, logic [4:0] lb, logic [1:0] mv);
    answer_t ans;
    int ra, rb, keep, sub, t;
    ans = '0;
    case (cmd)
      puf_pkg::CMD_ADD: begin
        if (pairs_added >= puf_pkg::MAX_PAIRS) ans.status = puf_pkg::STAT_FULL;
        else begin
          tab_first[pairs_added] = la;
          tab_second[pairs_added] = lb;
          tab_truth[pairs_added] = 1'b1;
          tab_parent[pairs_added] = pairs_added;
          tab_size[pairs_added] = 1;
          tab_ring[pairs_added] = pairs_added;
          ans.value = 7'(pairs_added);
          pairs_added++;
        end
      end
      puf_pkg::CMD_UNITE: begin
        if (ia >= pairs_added || ib >= pairs_added) ans.status = puf_pkg::STAT_NOT_ADDED;
        else begin
          ra = find_root(ia);
          rb = find_root(ib);
          keep = ra;
          if (ra != rb) begin
            sub = rb;
            if (tab_size[ra] < tab_size[rb]) begin
              keep = rb;
              sub = ra;
            end
            if (!tab_truth[sub]) tab_truth[keep] = 1'b0;
            if (tab_truth[keep] && groups_clash(ra, rb)) begin
              tab_truth[keep] = 1'b0;
              ans.contra = 1'b1;
            end
            tab_parent[sub] = keep;
            tab_size[keep] += tab_size[sub];
            t = tab_ring[ra];
            tab_ring[ra] = tab_ring[rb];
            tab_ring[rb] = t;
          end
          ans.value = 7'(tab_size[keep]);
          ans.flag = tab_truth[keep];
        end
      end
      puf_pkg::CMD_SIZE: begin
        if (ia >= pairs_added) ans.status = puf_pkg::STAT_NOT_ADDED;
        else ans.value = 7'(tab_size[find_root(ia)]);
      end
      puf_pkg::CMD_LOOKUP: begin
        for (int k = 0; k < pairs_added; k++) begin
          if ((tab_first[k] == la && tab_second[k] == lb) ||
              (tab_second[k] == la && tab_first[k] == lb)) begin
            ans.value = 7'(k);
            ans.flag = 1'b1;
            break;
          end
        end
      end
      puf_pkg::CMD_SAME: begin
        if (ia >= pairs_added || ib >= pairs_added) ans.status = puf_pkg::STAT_NOT_ADDED;
        else ans.flag = (find_root(ia) == find_root(ib));
      end
      puf_pkg::CMD_MARK: begin
        if (mv > 1) ans.status = puf_pkg::STAT_BAD_MARK;
        else if (ia >= pairs_added) ans.status = puf_pkg::STAT_NOT_ADDED;
        else tab_truth[find_root(ia)] = mv[0];
      end
      puf_pkg::CMD_TRUTH: begin
        if (ia >= pairs_added) ans.status = puf_pkg::STAT_NOT_ADDED;
        else ans.flag = tab_truth[find_root(ia)];
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch on result %0d: %s got %0d expected %0d", got_cnt, what, got, want);
  endtask

  // valid stays high between back-to-back transfers; drop it only for a gap
  task automatic send_command(logic [2:0] cmd, int ia, int ib,
                              logic [4:0] la, logic [4:0] lb, logic [1:0] mv);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (hold_off) gap = 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    answers_due.push_back(run_command(cmd, ia, ib, la, lb, mv));
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, mv, lb, la, ib[5:0], ia[5:0], cmd};
    do @(posedge clk); while (!s_tready);
    sent_cnt++;
  endtask

  // pick an index mostly among added entries, sometimes beyond
  function automatic int pick_index();
    if (pairs_added == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, pairs_added - 1);
  endfunction

  // draw a random wait after each result transfer; ready stays low until it runs out
  always @(posedge clk) begin
    if (rst || rx_stall_on) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      rx_draw = $urandom_range(0, 17);
      rx_wait <= rx_draw;
      m_tready <= (rx_draw == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[10:0];
      got_cnt++;
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = answers_due.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.value != want.value) report_mismatch("value", got.value, want.value);
        if (got.flag != want.flag) report_mismatch("flag", got.flag, want.flag);
        if (got.contra != want.contra) report_mismatch("contradiction", got.contra, want.contra);
        if (want.contra) contra_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WAIT_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_command(puf_pkg::CMD_SIZE, 0, 0, 0, 0, 0);
    send_command(puf_pkg::CMD_MARK, 0, 0, 0, 0, 2'd3);
    send_command(puf_pkg::CMD_MARK, 0, 0, 0, 0, 2'd1);
    send_command(puf_pkg::CMD_ADD, 0, 0, 5'd0, 5'd25, 0);
    send_command(puf_pkg::CMD_ADD, 0, 0, 5'd1, 5'd2, 0);
    send_command(puf_pkg::CMD_ADD, 0, 0, 5'd0, 5'd3, 0);
    send_command(puf_pkg::CMD_ADD, 0, 0, 5'd31, 5'd30, 0);
    send_command(puf_pkg::CMD_UNITE, 0, 1, 0, 0, 0);
    send_command(puf_pkg::CMD_UNITE, 1, 2, 0, 0, 0);
    send_command(puf_pkg::CMD_UNITE, 2, 0, 0, 0, 0);
    send_command(puf_pkg::CMD_UNITE, 3, 63, 0, 0, 0);
    send_command(puf_pkg::CMD_SAME, 0, 2, 0, 0, 0);
    send_command(puf_pkg::CMD_SAME, 0, 3, 0, 0, 0);
    send_command(puf_pkg::CMD_TRUTH, 1, 0, 0, 0, 0);
    send_command(puf_pkg::CMD_MARK, 3, 0, 0, 0, 2'd0);
    send_command(puf_pkg::CMD_UNITE, 3, 0, 0, 0, 0);
    send_command(puf_pkg::CMD_MARK, 0, 0, 0, 0, 2'd2);
    send_command(puf_pkg::CMD_LOOKUP, 0, 0, 5'd25, 5'd0, 0);
    send_command(puf_pkg::CMD_LOOKUP, 0, 0, 5'd30, 5'd31, 0);
    send_command(puf_pkg::CMD_LOOKUP, 0, 0, 5'd7, 5'd8, 0);
    send_command(puf_pkg::CMD_SIZE, 2, 0, 0, 0, 0);
    send_command(3'd7, 63, 63, 5'd31, 5'd31, 2'd3);
  endtask

  task automatic test_random(int count);
    logic [2:0] cmd;
    for (int n = 0; n < count; n++) begin
      if (pairs_added < puf_pkg::MAX_PAIRS && $urandom_range(0, 4) == 0) cmd = puf_pkg::CMD_ADD;
      else cmd = 3'($urandom_range(0, 7));
      // small alphabet makes shared letters and clashes common
      send_command(cmd, pick_index(), pick_index(),
                   $urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(0, 6)),
                   $urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(0, 6)),
                   2'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_full_table();
    while (pairs_added < puf_pkg::MAX_PAIRS)
      send_command(puf_pkg::CMD_ADD, 0, 0, 5'($urandom_range(0, 31)),
                   5'($urandom_range(0, 31)), 0);
    send_command(puf_pkg::CMD_ADD, 63, 63, 5'd31, 5'd31, 2'd3);
    send_command(puf_pkg::CMD_UNITE, 63, 0, 0, 0, 0);
    send_command(puf_pkg::CMD_TRUTH, 63, 0, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    rx_stall_on = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        rx_stall_on = 1'b0;
      end
      test_random(12);
    join
    hold_off = 1'b0;
  endtask

  initial begin
    errors = 0;
    pairs_added = 0;
    rx_wait = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250);
    test_backpressure();
    test_random(250);
    test_full_table();
    test_random(300);
    s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("Sent %0d commands, checked %0d results, %0d contradictions.",
             sent_cnt, got_cnt, contra_cnt);
    if (errors == 0 && answers_due.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
